// ===== design/dscm_pkg.sv =====
// Shared constants, codes and types for the drive and steering command mapper.
package dscm_pkg;

   // Fixed-point unit: 4096 stands for 1.0 (Q12 fraction).
   localparam int unsigned Q12_ONE = 4096;
   // Largest magnitude that still counts as "no motion" (|x| * 100 <= 4096).
   localparam int unsigned ACT_LIMIT = Q12_ONE / 100;
   // Largest drive magnitude inside the deadband (|x| * 20 < 4096).
   localparam int unsigned DEAD_LIMIT = Q12_ONE / 20;

   localparam int unsigned ANGLE_LIMIT = 180;
   localparam int unsigned PULSE_BASE  = 544;
   localparam int unsigned PULSE_SPAN  = 1856;
   localparam int unsigned PULSE_W     = 12;

   // Serial multiplier: one multiplier bit per cycle.
   localparam int unsigned MUL_W     = 16;
   localparam int unsigned MUL_CNT_W = $clog2(MUL_W);

   // Serial divider for the servo pulse: angle * 1856 fits in 19 bits.
   localparam int unsigned DIV_W         = 19;
   localparam int unsigned DIV_CNT_W     = $clog2(DIV_W);
   localparam int unsigned PULSE_DIVISOR = ANGLE_LIMIT;
   localparam int unsigned DIVISOR_W     = 8;
   localparam int unsigned QUO_W         = 11;

   // Register reset values.
   localparam logic [7:0]  RST_STEER_MIN    = 8'd115;
   localparam logic [7:0]  RST_STEER_CENTER = 8'd135;
   localparam logic [7:0]  RST_STEER_MAX    = 8'd145;
   localparam logic [7:0]  RST_DUTY_FLOOR   = 8'd60;
   localparam logic [7:0]  RST_DUTY_CEILING = 8'd255;
   localparam logic [15:0] RST_SPEED_GAIN   = 16'd4096;
   localparam logic [15:0] RST_TURN_GAIN    = 16'd4096;
   localparam logic [15:0] RST_TIMEOUT_MS   = 16'd1000;

   typedef enum logic [2:0] {
      REQ_VELOCITY = 3'd0,
      REQ_DRIVE    = 3'd1,
      REQ_STEER    = 3'd2,
      REQ_BRAKE    = 3'd3,
      REQ_TICK     = 3'd4
   } req_kind_type;

   typedef enum logic [2:0] {
      CSR_STEER_MIN    = 3'd0,
      CSR_STEER_CENTER = 3'd1,
      CSR_STEER_MAX    = 3'd2,
      CSR_DUTY_FLOOR   = 3'd3,
      CSR_DUTY_CEILING = 3'd4,
      CSR_SPEED_GAIN   = 3'd5,
      CSR_TURN_GAIN    = 3'd6,
      CSR_TIMEOUT_MS   = 3'd7
   } csr_index_type;

endpackage

// ===== design/dscm_ser_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
module dscm_ser_mul (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dscm_pkg::MUL_W-1:0]       mul_a,
   input  logic [dscm_pkg::MUL_W-1:0]       mul_b,
   output logic                             done,
   output logic [2*dscm_pkg::MUL_W-1:0]     product
);

   localparam int unsigned W = dscm_pkg::MUL_W;

   logic [2*W-1:0]                    acc_ff, acc_in;
   logic [W-1:0]                      a_ff, a_in;
   logic [dscm_pkg::MUL_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [W:0]                        sum;

   // The low half starts as the multiplier and shifts out LSB first while
   // partial sums enter the high half.
   always_comb begin
      sum     = {1'b0, acc_ff[2*W-1:W]} + {1'b0, (acc_ff[0] ? a_ff : {W{1'b0}})};
      acc_in  = acc_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = {{W{1'b0}}, mul_b};
         a_in    = mul_a;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == dscm_pkg::MUL_CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ===== design/dscm_ser_div.sv =====
// Restoring divider by the constant 180, one quotient bit per cycle.
module dscm_ser_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [dscm_pkg::DIV_W-1:0]     dividend,
   output logic                           done,
   output logic [dscm_pkg::QUO_W-1:0]     quotient
);

   localparam int unsigned W  = dscm_pkg::DIV_W;
   localparam int unsigned DW = dscm_pkg::DIVISOR_W;

   logic [DW-1:0]                     rem_ff, rem_in;
   logic [W-1:0]                      shf_ff, shf_in;
   logic [dscm_pkg::DIV_CNT_W-1:0]    cnt_ff, cnt_in;
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [DW:0]                       trial;
   logic                              fits;

   // Dividend bits leave the top of the shift register while quotient bits
   // enter at the bottom.
   always_comb begin
      trial   = {rem_ff, shf_ff[W-1]};
      fits    = trial >= (DW + 1)'(dscm_pkg::PULSE_DIVISOR);
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         shf_in  = dividend;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? DW'(trial - (DW + 1)'(dscm_pkg::PULSE_DIVISOR)) : trial[DW-1:0];
         shf_in = {shf_ff[W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == dscm_pkg::DIV_CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
   end

   assign done     = done_ff;
   assign quotient = shf_ff[dscm_pkg::QUO_W-1:0];

endmodule

// ===== design/drive_steer_command_mapper_unit.sv =====
// Top level of the drive and steering command mapper: sequencer, state and ports.
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_tvalid/req_tready  req_tdata (64), req_tuser (3)
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata (32)
//   csr      in         csr_we                 csr_addr (3), csr_wdata (16)
//
// One request is worked on at a time. A tick, steer, brake or unknown request
// goes from decode straight to the 19-bit serial divider for the servo pulse.
// A velocity request with both linear and turn input makes up to four passes
// through the shared serial multiplier (speed, duty, turn and steering span;
// duty is skipped inside the deadband), then goes to the divider.
// Reset is synchronous and returns the configuration, mapper state, sequencer and
// response valid to reset values; latched request and working data are not reset.
// A new request is taken while the previous response still waits; the block stalls
// only if it finishes again before that response has been taken.
module drive_steer_command_mapper_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_tdata, from bit 0 up: linear_speed (16), turn_rate (16),
   // drive_level (16), steer_request (16)
   input  logic [63:0] req_tdata,
   // req_tuser: req_type (3)
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // rsp_tdata, from bit 0 up: duty (8), direction (2), steering angle (8),
   // servo_pulse_us (12), watchdog_armed (1), watchdog_fired (1)
   output logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   // One-hot sequencer states.
   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_DECODE = 12'b0000_0000_0010,
      ST_SPEED  = 12'b0000_0000_0100,
      ST_DRIVE  = 12'b0000_0000_1000,
      ST_DUTY   = 12'b0000_0001_0000,
      ST_TURN   = 12'b0000_0010_0000,
      ST_TURNW  = 12'b0000_0100_0000,
      ST_SPAN   = 12'b0000_1000_0000,
      ST_STEERW = 12'b0001_0000_0000,
      ST_PULSE  = 12'b0010_0000_0000,
      ST_PULSEW = 12'b0100_0000_0000,
      ST_EMIT   = 12'b1000_0000_0000
   } state_type;

   localparam int unsigned MW = dscm_pkg::MUL_W;

   // Magnitude of a two's complement word; the most negative value maps to 2^15.
   function automatic logic [15:0] mag16(input logic [15:0] x);
      return x[15] ? (~x + 16'd1) : x;
   endfunction

   // Clamp to the minimum, then the maximum (maximum wins when they cross),
   // then to the mechanical range 0 to 180 degrees.
   function automatic logic [7:0] steer_clamp(input logic signed [16:0] a,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
      logic signed [16:0] r;
      r = a;
      if (r < $signed({9'b0, lo})) r = $signed({9'b0, lo});
      if (r > $signed({9'b0, hi})) r = $signed({9'b0, hi});
      if (r < 17'sd0) r = 17'sd0;
      if (r > $signed(17'(dscm_pkg::ANGLE_LIMIT))) r = $signed(17'(dscm_pkg::ANGLE_LIMIT));
      return r[7:0];
   endfunction

   state_type state_ff, state_in;

   // Configuration registers.
   logic [7:0]  steer_min_ff, steer_min_in;
   logic [7:0]  center_ff, center_in;
   logic [7:0]  steer_max_ff, steer_max_in;
   logic [7:0]  floor_ff, floor_in;
   logic [7:0]  ceiling_ff, ceiling_in;
   logic [15:0] speed_gain_ff, speed_gain_in;
   logic [15:0] turn_gain_ff, turn_gain_in;
   logic [15:0] timeout_ff, timeout_in;

   // Latched request.
   logic [2:0]         kind_ff, kind_in;
   logic signed [15:0] lin_ff, lin_in;
   logic signed [15:0] ang_ff, ang_in;
   logic signed [15:0] drv_ff, drv_in;
   logic signed [15:0] str_ff, str_in;

   // Mapper state.
   logic [15:0]        idle_ff, idle_in;
   logic               armed_ff, armed_in;
   logic               running_ff, running_in;
   logic [7:0]         duty_ff, duty_in;
   logic [1:0]         dir_ff, dir_in;
   logic [7:0]         angle_ff, angle_in;
   logic               fired_ff, fired_in;

   // Working registers between multiplier passes.
   logic signed [13:0] lvl_ff, lvl_in;
   logic [12:0]        nm_ff, nm_in;
   logic [dscm_pkg::PULSE_W-1:0] pulse_ff, pulse_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [31:0]        rsp_data_ff, rsp_data_in;

   // Shared serial units.
   logic               mul_start, mul_done;
   logic [MW-1:0]      mul_a, mul_b;
   logic [2*MW-1:0]    mul_prod;
   logic               div_start, div_done;
   logic [dscm_pkg::DIV_W-1:0] div_dividend;
   logic [dscm_pkg::QUO_W-1:0] div_q;

   // Derived values.
   logic [15:0]        lin_mag, ang_mag;
   logic               lin_act, ang_act;
   logic [19:0]        prod_q;
   logic [12:0]        prod_sat;
   logic signed [13:0] lin_lvl;
   logic signed [13:0] drv_lvl;
   logic [13:0]        lvl_abs;
   logic [12:0]        lvl_mag;
   logic [8:0]         dspan;
   logic [7:0]         dmag;
   logic [20:0]        total;
   logic [7:0]         pwm;
   logic               n_neg;
   logic [8:0]         span9;
   logic [7:0]         smag;
   logic signed [16:0] angle_goal;
   logic [15:0]        idle_nx;
   logic               fire;
   logic               turn_next;

   dscm_ser_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   dscm_ser_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      lin_mag = mag16(lin_ff);
      ang_mag = mag16(ang_ff);
      lin_act = lin_mag > 16'(dscm_pkg::ACT_LIMIT);
      ang_act = ang_mag > 16'(dscm_pkg::ACT_LIMIT);

      // Q12 scaling: drop twelve fraction bits, saturate at 1.0.
      prod_q   = mul_prod[31:12];
      prod_sat = (prod_q > 20'(dscm_pkg::Q12_ONE)) ? 13'(dscm_pkg::Q12_ONE) : prod_q[12:0];
      lin_lvl  = lin_ff[15] ? -$signed({1'b0, prod_sat}) : $signed({1'b0, prod_sat});

      if (drv_ff > $signed(16'(dscm_pkg::Q12_ONE))) begin
         drv_lvl = $signed(14'(dscm_pkg::Q12_ONE));
      end else if (drv_ff < -$signed(16'(dscm_pkg::Q12_ONE))) begin
         drv_lvl = -$signed(14'(dscm_pkg::Q12_ONE));
      end else begin
         drv_lvl = drv_ff[13:0];
      end

      lvl_abs = lvl_ff[13] ? 14'(-lvl_ff) : 14'(lvl_ff);
      lvl_mag = lvl_abs[12:0];

      // Duty = (floor * 4096 + m * (ceiling - floor)) >> 12. The sum never goes
      // negative because m is at most 4096.
      dspan = {1'b0, ceiling_ff} - {1'b0, floor_ff};
      dmag  = dspan[8] ? 8'(-dspan) : dspan[7:0];
      total = dspan[8] ? ({1'b0, floor_ff, 12'b0} - {1'b0, mul_prod[19:0]})
                       : ({1'b0, floor_ff, 12'b0} + {1'b0, mul_prod[19:0]});
      pwm   = total[19:12];

      // Steering uses the half of the range on the side of the turn.
      n_neg = ang_ff[15];
      span9 = n_neg ? ({1'b0, center_ff} - {1'b0, steer_min_ff})
                    : ({1'b0, steer_max_ff} - {1'b0, center_ff});
      smag  = span9[8] ? 8'(-span9) : span9[7:0];
      angle_goal = (n_neg ^ span9[8])
                 ? $signed({9'b0, center_ff}) - $signed({9'b0, mul_prod[19:12]})
                 : $signed({9'b0, center_ff}) + $signed({9'b0, mul_prod[19:12]});

      idle_nx = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      fire    = armed_ff && running_ff && (idle_nx > timeout_ff);

      // After the drive update a velocity request with a turn goes on to steer.
      turn_next = (kind_ff == dscm_pkg::REQ_VELOCITY) && ang_act;

      div_dividend = dscm_pkg::DIV_W'(angle_ff) * dscm_pkg::DIV_W'(dscm_pkg::PULSE_SPAN);
   end

   // Configuration writes.
   always_comb begin
      steer_min_in  = steer_min_ff;
      center_in     = center_ff;
      steer_max_in  = steer_max_ff;
      floor_in      = floor_ff;
      ceiling_in    = ceiling_ff;
      speed_gain_in = speed_gain_ff;
      turn_gain_in  = turn_gain_ff;
      timeout_in    = timeout_ff;
      if (csr_we) begin
         case (csr_addr)
            dscm_pkg::CSR_STEER_MIN:    steer_min_in  = csr_wdata[7:0];
            dscm_pkg::CSR_STEER_CENTER: center_in     = csr_wdata[7:0];
            dscm_pkg::CSR_STEER_MAX:    steer_max_in  = csr_wdata[7:0];
            dscm_pkg::CSR_DUTY_FLOOR:   floor_in      = csr_wdata[7:0];
            dscm_pkg::CSR_DUTY_CEILING: ceiling_in    = csr_wdata[7:0];
            dscm_pkg::CSR_SPEED_GAIN:   speed_gain_in = csr_wdata;
            dscm_pkg::CSR_TURN_GAIN:    turn_gain_in  = csr_wdata;
            dscm_pkg::CSR_TIMEOUT_MS:   timeout_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer. Each velocity request walks speed scaling, drive mapping,
   // turn scaling and the steering map, skipping what the inputs do not need.
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      lin_in       = lin_ff;
      ang_in       = ang_ff;
      drv_in       = drv_ff;
      str_in       = str_ff;
      idle_in      = idle_ff;
      armed_in     = armed_ff;
      running_in   = running_ff;
      duty_in      = duty_ff;
      dir_in       = dir_ff;
      angle_in     = angle_ff;
      fired_in     = fired_ff;
      lvl_in       = lvl_ff;
      nm_in        = nm_ff;
      pulse_in     = pulse_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mul_start    = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               lin_in   = req_tdata[15:0];
               ang_in   = req_tdata[31:16];
               drv_in   = req_tdata[47:32];
               str_in   = req_tdata[63:48];
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            fired_in = 1'b0;
            state_in = ST_PULSE;
            case (kind_ff)
               dscm_pkg::REQ_VELOCITY: begin
                  idle_in  = '0;
                  armed_in = 1'b1;
                  if (lin_act) begin
                     mul_start = 1'b1;
                     mul_a     = lin_mag;
                     mul_b     = speed_gain_ff;
                     state_in  = ST_SPEED;
                  end else if (!ang_act) begin
                     // Both inputs at rest: stop and straighten the wheels.
                     running_in = 1'b0;
                     duty_in    = '0;
                     dir_in     = '0;
                     angle_in   = steer_clamp($signed({9'b0, center_ff}),
                                              steer_min_ff, steer_max_ff);
                  end else begin
                     state_in = ST_TURN;
                  end
               end
               dscm_pkg::REQ_DRIVE: begin
                  idle_in  = '0;
                  lvl_in   = drv_lvl;
                  state_in = ST_DRIVE;
               end
               dscm_pkg::REQ_STEER: begin
                  idle_in  = '0;
                  angle_in = steer_clamp({str_ff[15], str_ff}, steer_min_ff, steer_max_ff);
               end
               dscm_pkg::REQ_BRAKE: begin
                  running_in = 1'b0;
                  duty_in    = '0;
                  dir_in     = '0;
                  armed_in   = 1'b0;
                  angle_in   = (center_ff > 8'(dscm_pkg::ANGLE_LIMIT))
                             ? 8'(dscm_pkg::ANGLE_LIMIT) : center_ff;
               end
               dscm_pkg::REQ_TICK: begin
                  idle_in = idle_nx;
                  if (fire) begin
                     running_in = 1'b0;
                     duty_in    = '0;
                     dir_in     = '0;
                     armed_in   = 1'b0;
                     fired_in   = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_SPEED: begin
            if (mul_done) begin
               lvl_in   = lin_lvl;
               state_in = ST_DRIVE;
            end
         end
         ST_DRIVE: begin
            if (lvl_mag <= 13'(dscm_pkg::DEAD_LIMIT)) begin
               // Inside the deadband the motor stops.
               running_in = 1'b0;
               duty_in    = '0;
               dir_in     = '0;
               state_in   = turn_next ? ST_TURN : ST_PULSE;
            end else begin
               mul_start = 1'b1;
               mul_a     = MW'(lvl_mag);
               mul_b     = MW'(dmag);
               state_in  = ST_DUTY;
            end
         end
         ST_DUTY: begin
            if (mul_done) begin
               if (pwm == 8'd0) begin
                  running_in = 1'b0;
                  duty_in    = '0;
                  dir_in     = '0;
               end else begin
                  running_in = 1'b1;
                  duty_in    = pwm;
                  dir_in     = lvl_ff[13] ? 2'b11 : 2'b01;
               end
               state_in = turn_next ? ST_TURN : ST_PULSE;
            end
         end
         ST_TURN: begin
            mul_start = 1'b1;
            mul_a     = ang_mag;
            mul_b     = turn_gain_ff;
            state_in  = ST_TURNW;
         end
         ST_TURNW: begin
            if (mul_done) begin
               nm_in    = prod_sat;
               state_in = ST_SPAN;
            end
         end
         ST_SPAN: begin
            mul_start = 1'b1;
            mul_a     = MW'(nm_ff);
            mul_b     = MW'(smag);
            state_in  = ST_STEERW;
         end
         ST_STEERW: begin
            if (mul_done) begin
               idle_in  = '0;
               angle_in = steer_clamp(angle_goal, steer_min_ff, steer_max_ff);
               state_in = ST_PULSE;
            end
         end
         ST_PULSE: begin
            div_start = 1'b1;
            state_in  = ST_PULSEW;
         end
         ST_PULSEW: begin
            if (div_done) begin
               pulse_in = dscm_pkg::PULSE_W'(dscm_pkg::PULSE_BASE)
                        + dscm_pkg::PULSE_W'(div_q);
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Wait here only while the previous response is still unclaimed.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = {fired_ff, armed_ff, pulse_ff, angle_ff, dir_ff, duty_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         steer_min_ff  <= dscm_pkg::RST_STEER_MIN;
         center_ff     <= dscm_pkg::RST_STEER_CENTER;
         steer_max_ff  <= dscm_pkg::RST_STEER_MAX;
         floor_ff      <= dscm_pkg::RST_DUTY_FLOOR;
         ceiling_ff    <= dscm_pkg::RST_DUTY_CEILING;
         speed_gain_ff <= dscm_pkg::RST_SPEED_GAIN;
         turn_gain_ff  <= dscm_pkg::RST_TURN_GAIN;
         timeout_ff    <= dscm_pkg::RST_TIMEOUT_MS;
         idle_ff       <= '0;
         armed_ff      <= 1'b0;
         running_ff    <= 1'b0;
         duty_ff       <= '0;
         dir_ff        <= '0;
         angle_ff      <= dscm_pkg::RST_STEER_CENTER;
         fired_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         steer_min_ff  <= steer_min_in;
         center_ff     <= center_in;
         steer_max_ff  <= steer_max_in;
         floor_ff      <= floor_in;
         ceiling_ff    <= ceiling_in;
         speed_gain_ff <= speed_gain_in;
         turn_gain_ff  <= turn_gain_in;
         timeout_ff    <= timeout_in;
         idle_ff       <= idle_in;
         armed_ff      <= armed_in;
         running_ff    <= running_in;
         duty_ff       <= duty_in;
         dir_ff        <= dir_in;
         angle_ff      <= angle_in;
         fired_ff      <= fired_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      lin_ff      <= lin_in;
      ang_ff      <= ang_in;
      drv_ff      <= drv_in;
      str_ff      <= str_in;
      lvl_ff      <= lvl_in;
      nm_ff       <= nm_in;
      pulse_ff    <= pulse_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A multiplier result must land while the sequencer is waiting for it.
   a_mul_done_waits: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_SPEED || state_ff == ST_DUTY ||
                    state_ff == ST_TURNW || state_ff == ST_STEERW))
      else $error("multiplier finished outside a wait state");

   a_div_done_waits: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_PULSEW))
      else $error("divider finished outside the pulse wait state");

   // Running, a nonzero duty and a nonzero direction always go together.
   a_motor_consistent: assert property (@(posedge clock) disable iff (reset)
      (running_ff == (duty_ff != 8'd0)) && (running_ff == (dir_ff != 2'd0)))
      else $error("motor state registers disagree");

   a_angle_in_range: assert property (@(posedge clock) disable iff (reset)
      angle_ff <= 8'(dscm_pkg::ANGLE_LIMIT))
      else $error("steering angle beyond mechanical range");

endmodule

// ===== test/drive_steer_checker.sv =====
// Checker for the drive and steering command mapper: predicts and compares every response.
`timescale 1ns / 100ps

module drive_steer_checker
   import dscm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          outstanding
);

   localparam int ONE       = Q12_ONE;
   localparam int MAX_ANGLE = ANGLE_LIMIT;
   localparam int MAX_IDLE  = 65535;

   typedef struct {
      logic [7:0]  duty;
      logic [1:0]  direction;
      logic [7:0]  angle;
      logic [11:0] pulse;
      logic        armed;
      logic        fired;
   } drive_status_type;

   drive_status_type expected_status[$];
   drive_status_type want, got;
   int               errors = 0;

   // Register copies.
   int angle_min, angle_center, angle_max, floor_duty, ceiling_duty;
   int linear_gain, angular_gain, idle_limit;

   // Mapper state.
   int idle_ms, duty_now, dir_now, angle_now;
   bit wd_armed, motor_on;

   function automatic int magnitude(int x);
      return (x < 0) ? -x : x;
   endfunction

   // Gain scaling truncates the magnitude and saturates at one.
   function automatic int scale_by_gain(int x, int gain);
      longint p;
      p = (longint'(magnitude(x)) * longint'(gain)) >>> 12;
      if (p > ONE) p = ONE;
      return (x < 0) ? -int'(p) : int'(p);
   endfunction

   function automatic void stop_motor();
      duty_now = 0;
      dir_now  = 0;
      motor_on = 1'b0;
   endfunction

   function automatic void apply_drive(int level);
      int         m;
      longint     total;
      logic [7:0] pwm;
      if (level > ONE) level = ONE;
      if (level < -ONE) level = -ONE;
      idle_ms = 0;
      m = magnitude(level);
      if (m * 20 < ONE) begin
         stop_motor();
         return;
      end
      total = longint'(floor_duty) * ONE
            + longint'(m) * (longint'(ceiling_duty) - longint'(floor_duty));
      if (total < 0) total = 0;
      pwm = total[19:12];
      if (pwm == 8'd0) begin
         stop_motor();
         return;
      end
      duty_now = pwm;
      dir_now  = (level >= 0) ? 1 : -1;
      motor_on = 1'b1;
   endfunction

   // The upper limit wins when the limits cross, then the servo range applies.
   function automatic void apply_steer(int a);
      idle_ms = 0;
      if (a < angle_min) a = angle_min;
      if (a > angle_max) a = angle_max;
      if (a < 0) a = 0;
      if (a > MAX_ANGLE) a = MAX_ANGLE;
      angle_now = a;
   endfunction

   function automatic void apply_velocity(int lin, int turn);
      int lm, am, n, span;
      lm = magnitude(lin);
      am = magnitude(turn);
      idle_ms  = 0;
      wd_armed = 1'b1;
      if (lm * 100 > ONE) begin
         apply_drive(scale_by_gain(lin, linear_gain));
      end else if (am * 100 < ONE) begin
         apply_drive(0);
         apply_steer(angle_center);
      end
      // A turn-only command steers and leaves the motor as it was.
      if (am * 100 > ONE) begin
         n    = scale_by_gain(turn, angular_gain);
         span = (n >= 0) ? angle_max - angle_center : angle_center - angle_min;
         apply_steer(angle_center + (n * span) / ONE);
      end
   endfunction

   function automatic drive_status_type predict_status(logic [2:0] kind,
                                                       logic [63:0] payload);
      drive_status_type s;
      s.fired = 1'b0;
      case (kind)
         REQ_VELOCITY: apply_velocity(int'($signed(payload[15:0])),
                                      int'($signed(payload[31:16])));
         REQ_DRIVE:    apply_drive(int'($signed(payload[47:32])));
         REQ_STEER:    apply_steer(int'($signed(payload[63:48])));
         REQ_BRAKE: begin
            stop_motor();
            angle_now = (angle_center > MAX_ANGLE) ? MAX_ANGLE : angle_center;
            wd_armed  = 1'b0;
         end
         REQ_TICK: begin
            if (idle_ms < MAX_IDLE) idle_ms++;
            if (wd_armed && motor_on && idle_ms > idle_limit) begin
               stop_motor();
               wd_armed = 1'b0;
               s.fired  = 1'b1;
            end
         end
         default: ;
      endcase
      s.duty      = 8'(duty_now);
      s.direction = 2'(dir_now);
      s.angle     = 8'(angle_now);
      s.pulse     = 12'(PULSE_BASE + angle_now * PULSE_SPAN / ANGLE_LIMIT);
      s.armed     = wd_armed;
      return s;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         angle_min    = RST_STEER_MIN;
         angle_center = RST_STEER_CENTER;
         angle_max    = RST_STEER_MAX;
         floor_duty   = RST_DUTY_FLOOR;
         ceiling_duty = RST_DUTY_CEILING;
         linear_gain  = RST_SPEED_GAIN;
         angular_gain = RST_TURN_GAIN;
         idle_limit   = RST_TIMEOUT_MS;
         idle_ms      = 0;
         wd_armed     = 1'b0;
         motor_on     = 1'b0;
         duty_now     = 0;
         dir_now      = 0;
         angle_now    = RST_STEER_CENTER;
         expected_status.delete();
      end else begin
         // Responses are checked before this edge's request is predicted.
         if (rsp_tvalid && rsp_tready) begin
            got.duty      = rsp_tdata[7:0];
            got.direction = rsp_tdata[9:8];
            got.angle     = rsp_tdata[17:10];
            got.pulse     = rsp_tdata[29:18];
            got.armed     = rsp_tdata[30];
            got.fired     = rsp_tdata[31];
            if (expected_status.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: response %h arrived with no request waiting",
                           $time, rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               if (want.duty !== got.duty || want.direction !== got.direction ||
                   want.angle !== got.angle || want.pulse !== got.pulse ||
                   want.armed !== got.armed || want.fired !== got.fired) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: mismatch, expected duty %0d dir %0d angle %0d pulse %0d armed %0b fired %0b",
                              $time, want.duty, $signed(want.direction), want.angle,
                              want.pulse, want.armed, want.fired);
                     $display("%0t: mismatch, actual   duty %0d dir %0d angle %0d pulse %0d armed %0b fired %0b",
                              $time, got.duty, $signed(got.direction), got.angle,
                              got.pulse, got.armed, got.fired);
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_addr)
               CSR_STEER_MIN:    angle_min    = csr_wdata[7:0];
               CSR_STEER_CENTER: angle_center = csr_wdata[7:0];
               CSR_STEER_MAX:    angle_max    = csr_wdata[7:0];
               CSR_DUTY_FLOOR:   floor_duty   = csr_wdata[7:0];
               CSR_DUTY_CEILING: ceiling_duty = csr_wdata[7:0];
               CSR_SPEED_GAIN:   linear_gain  = csr_wdata;
               CSR_TURN_GAIN:    angular_gain = csr_wdata;
               CSR_TIMEOUT_MS:   idle_limit   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            expected_status.push_back(predict_status(req_tuser, req_tdata));
      end
      outstanding    <= expected_status.size();
      mismatch_count <= errors;
   end

endmodule

// ===== test/testbench.sv =====
// Top of the testbench for the drive and steering command mapper: stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
   import dscm_pkg::*;

   // Length of the one long receiver hold-off that backs the block up.
   localparam int LONG_HOLD   = 300;
   // Random requests per register setting.
   localparam int PHASE_ITEMS = 88;
   // Cycles to watch for stray responses after the last one is expected.
   localparam int SETTLE      = 120;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [2:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   int mismatch_count;
   int outstanding;

   // Idling controls, written by the stimulus process only.
   int send_idle_pct = 0;
   int stall_pct     = 0;
   bit hold_request  = 1'b0;

   // Receiver-side hold-off bookkeeping, owned by the receiver process.
   int hold_count = 0;
   bit hold_done  = 1'b0;

   logic [15:0] reg_values [8];

   always #2 clock = ~clock;

   drive_steer_command_mapper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   drive_steer_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // The receiver stalls at random per the current phase. Once a hold-off is
   // requested it refuses responses for a long stretch while the sender keeps
   // offering, so the block ends up holding a response and stalls its input.
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count++;
         if (hold_count == LONG_HOLD) hold_done = 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Packs the four request fields into tdata, linear speed in the low bits.
   function automatic logic [63:0] pack_request(int lin, int turn, int level, int angle);
      return {16'(angle), 16'(level), 16'(turn), 16'(lin)};
   endfunction

   // A Q3.12 value that favors the activity and deadband edges and the
   // clamp at one, with full-range values mixed in to exercise every bit.
   function automatic int random_level();
      int edges[6] = '{40, 41, 204, 205, 4096, 4097};
      int pick;
      case ($urandom_range(9))
         0, 1: return int'($signed(16'($urandom)));
         2, 3: begin
            pick = $urandom_range(5);
            return $urandom_range(1) ? edges[pick] : -edges[pick];
         end
         4, 5, 6: return int'($urandom_range(12000)) - 6000;
         7: begin
            case ($urandom_range(3))
               0: return 32767;
               1: return -32768;
               2: return 0;
               default: return -1;
            endcase
         end
         default: return int'($urandom_range(600)) - 300;
      endcase
   endfunction

   // Steering requests mostly sit around the servo range, sometimes anywhere.
   function automatic int random_angle();
      if ($urandom_range(4) == 0) return int'($signed(16'($urandom)));
      return int'($urandom_range(220)) - 20;
   endfunction

   // Offers one request, after a random idle gap, and returns at the edge
   // where it was taken. The valid stays high into the next request when no
   // gap is drawn, so it is never lowered and raised in one time step.
   task automatic send_request(input logic [2:0] kind, input logic [63:0] payload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stops offering and waits until every predicted response has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Writes all eight registers on consecutive edges while the block is idle.
   task automatic write_registers();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= 3'(i);
         csr_wdata <= reg_values[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   initial begin
      #4_000_000;
      $display("[drive_steer_command_mapper_unit] ERROR");
      $finish;
   end

   initial begin
      int         sent;
      int         burst;
      int         pick;
      logic [2:0] kind;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests at the reset register values.
      send_request(REQ_TICK,     pack_request(0, 0, 0, 0));
      // Full forward, then full reverse with a hard turn.
      send_request(REQ_VELOCITY, pack_request(32767, 0, 0, 0));
      send_request(REQ_VELOCITY, pack_request(-32768, 32767, 0, 0));
      // Just above the activity threshold on both inputs; the drive falls in
      // the deadband and the steering offset truncates to zero.
      send_request(REQ_VELOCITY, pack_request(41, -41, 0, 0));
      // Both inputs just below the threshold: stop and center.
      send_request(REQ_VELOCITY, pack_request(-40, 40, 0, 0));
      send_request(REQ_VELOCITY, pack_request(4096, 0, 0, 0));
      // Turn only: the motor keeps its speed.
      send_request(REQ_VELOCITY, pack_request(0, -32768, 0, 0));
      send_request(REQ_VELOCITY, pack_request(40, 4096, 0, 0));
      send_request(REQ_VELOCITY, pack_request(0, 0, 0, 0));
      // Drive levels on both sides of the deadband edge and at the clamps.
      send_request(REQ_DRIVE,    pack_request(0, 0, 204, 0));
      send_request(REQ_DRIVE,    pack_request(0, 0, 205, 0));
      send_request(REQ_DRIVE,    pack_request(0, 0, -205, 0));
      send_request(REQ_DRIVE,    pack_request(0, 0, 32767, 0));
      send_request(REQ_DRIVE,    pack_request(0, 0, -32768, 0));
      send_request(REQ_TICK,     pack_request(0, 0, 0, 0));
      // Steering requests at the field extremes and the servo range ends.
      send_request(REQ_STEER,    pack_request(0, 0, 0, -32768));
      send_request(REQ_STEER,    pack_request(0, 0, 0, 32767));
      send_request(REQ_STEER,    pack_request(0, 0, 0, 0));
      send_request(REQ_STEER,    pack_request(0, 0, 0, 180));
      send_request(REQ_BRAKE,    pack_request(0, 0, 0, 0));
      // Unused request kinds leave the state alone.
      send_request(3'(REQ_TICK) + 3'd1, pack_request(-1, -1, -1, -1));
      send_request(3'(REQ_TICK) + 3'd2, pack_request(0, 0, 0, 0));
      send_request(3'(REQ_TICK) + 3'd3, pack_request(4096, 4096, 4096, 90));
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         // Register order: steer min, center, max, duty floor, duty ceiling,
         // speed gain, turn gain, timeout.
         case (phase)
            0: reg_values = '{16'd0, 16'd90, 16'd180, 16'd0, 16'd255,
                              16'd4096, 16'd4096, 16'd3};
            // Crossed limits and crossed duties at the extremes, zero timeout.
            1: reg_values = '{16'd180, 16'd0, 16'd0, 16'd255, 16'd0,
                              16'd65535, 16'd65535, 16'd0};
            2: reg_values = '{16'd60, 16'd90, 16'd120, 16'd100, 16'd200,
                              16'd8192, 16'd2048, 16'd5};
            // Zero gains, center above the upper limit, a timeout that never fires.
            4: reg_values = '{16'd150, 16'd180, 16'd170, 16'd30, 16'd30,
                              16'd0, 16'd0, 16'd65535};
            default: begin
               reg_values[CSR_STEER_MIN]    = 16'($urandom_range(180));
               reg_values[CSR_STEER_CENTER] = 16'($urandom_range(180));
               reg_values[CSR_STEER_MAX]    = 16'($urandom_range(180));
               reg_values[CSR_DUTY_FLOOR]   = 16'($urandom_range(255));
               reg_values[CSR_DUTY_CEILING] = 16'($urandom_range(255));
               reg_values[CSR_SPEED_GAIN]   = 16'($urandom_range(12288, 1024));
               reg_values[CSR_TURN_GAIN]    = 16'($urandom_range(12288, 1024));
               reg_values[CSR_TIMEOUT_MS]   = 16'($urandom_range(8));
            end
         endcase
         write_registers();

         // Idling per phase: none, sender idle, receiver stalling, both.
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct    <= 0;
            end
            1: begin
               send_idle_pct = 77;
               stall_pct    <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct    <= 77;
            end
            default: begin
               send_idle_pct = 35;
               stall_pct    <= 35;
            end
         endcase
         // The first phase also carries the long receiver hold-off.
         if (phase == 0) hold_request <= 1'b1;

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if ($urandom_range(99) < 12) begin
               // A velocity command followed by enough ticks to run the
               // watchdog past the timeout, or a dozen when it is long.
               send_request(REQ_VELOCITY, pack_request(random_level(), random_level(),
                                                       random_level(), random_angle()));
               burst = (reg_values[CSR_TIMEOUT_MS] > 10) ? 12 :
                       int'(reg_values[CSR_TIMEOUT_MS]) + 2;
               for (int t = 0; t < burst; t++)
                  send_request(REQ_TICK, pack_request(random_level(), random_level(),
                                                      random_level(), random_angle()));
               sent += burst + 1;
            end else begin
               pick = $urandom_range(99);
               if (pick < 28)      kind = REQ_VELOCITY;
               else if (pick < 40) kind = REQ_DRIVE;
               else if (pick < 52) kind = REQ_STEER;
               else if (pick < 57) kind = REQ_BRAKE;
               else if (pick < 95) kind = REQ_TICK;
               else                kind = 3'(REQ_TICK) + 3'($urandom_range(3, 1));
               send_request(kind, pack_request(random_level(), random_level(),
                                               random_level(), random_angle()));
               sent++;
            end
         end
         drain();
      end

      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[drive_steer_command_mapper_unit] OK");
      end else begin
         $display("[drive_steer_command_mapper_unit] ERROR");
      end
      $finish;
   end

endmodule
